// File: sv/idx_alloc_pkg.sv
// ----------------------------------------------------------------------------
// idx_alloc_pkg
// Shared types and constants for the deferred-release index allocator.
// ----------------------------------------------------------------------------
package idx_alloc_pkg;

   // Fixed widths of the request and response fields.
   localparam int IDX_W    = 9;
   localparam int STATUS_W = 2;

   // Request function codes.
   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      RC_OK         = 2'd0,
      RC_NONE_FREE  = 2'd1,
      RC_BUF_FULL   = 2'd2,
      RC_ZERO_INDEX = 2'd3
   } rsp_code_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FILL,
      S_FETCH,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_req;
      logic         buf_write;
      logic         res_load;
      rsp_code_type res_code;
      logic         res_from_stack;
      logic         fill_start;
      logic         fill_step;
      logic         fill_finish;
      logic         stk_read;
      logic         rsp_load;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_release;
      logic idx_zero;
      logic buf_full;
      logic buf_empty;
      logic stack_empty;
      logic fill_done;
   } dp_stat_type;

endpackage

// File: sv/idx_alloc_dp.sv
// ----------------------------------------------------------------------------
// idx_alloc_dp
// Datapath: allocation stack, release buffer, pointers and response registers.
// ----------------------------------------------------------------------------
module idx_alloc_dp #(
   parameter int SIZE = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_func,
   input  logic [idx_alloc_pkg::IDX_W-1:0]   req_index,
   input  idx_alloc_pkg::ctl_cmd_type        cmd,
   output idx_alloc_pkg::dp_stat_type        stat,
   output logic [idx_alloc_pkg::IDX_W-1:0]   rsp_granted_index,
   output logic [idx_alloc_pkg::STATUS_W-1:0] rsp_status
);
   import idx_alloc_pkg::*;

   localparam int ADDR_W = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int HEAD_W = $clog2(SIZE + 1);
   localparam int SUM_W  = (HEAD_W + 1 > IDX_W) ? HEAD_W + 1 : IDX_W;

   logic [IDX_W-1:0]    stack_mem_ff [SIZE];
   logic [IDX_W-1:0]    buf_mem_ff   [SIZE];

   logic                req_func_ff;
   logic [IDX_W-1:0]    req_index_ff;

   logic [HEAD_W-1:0]   head_ff, head_in;
   logic [HEAD_W-1:0]   count_ff, count_in;
   logic                refilled_ff, refilled_in;
   logic [HEAD_W-1:0]   fill_ptr_ff, fill_ptr_in;
   logic                fill_wr_valid_ff, fill_wr_valid_in;
   logic [ADDR_W-1:0]   fill_wr_addr_ff;
   logic [IDX_W-1:0]    fill_data_ff;

   logic [IDX_W-1:0]    stk_rd_ff;
   logic [IDX_W-1:0]    fresh_ff;
   logic                use_mem_ff;
   logic [SUM_W-1:0]    head_plus_one;
   logic                fill_more;

   logic [IDX_W-1:0]    res_granted_ff;
   rsp_code_type        res_code_ff;
   logic [IDX_W-1:0]    rsp_granted_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   assign head_plus_one = SUM_W'(head_ff) + SUM_W'(1);
   assign fill_more     = (fill_ptr_ff != count_ff);

   assign stat.is_release  = (req_func_ff == FUNC_RELEASE);
   assign stat.idx_zero    = (req_index_ff == '0);
   assign stat.buf_full    = (count_ff == HEAD_W'(SIZE));
   assign stat.buf_empty   = (count_ff == '0);
   assign stat.stack_empty = (head_ff == HEAD_W'(SIZE));
   assign stat.fill_done   = !fill_more && !fill_wr_valid_ff;

   // Control register next values.
   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      refilled_in      = refilled_ff;
      fill_ptr_in      = fill_ptr_ff;
      fill_wr_valid_in = fill_wr_valid_ff;
      if (cmd.buf_write) begin
         count_in = count_ff + HEAD_W'(1);
      end
      if (cmd.stk_read) begin
         head_in = head_ff + HEAD_W'(1);
      end
      if (cmd.fill_start) begin
         fill_ptr_in      = '0;
         fill_wr_valid_in = 1'b0;
      end
      if (cmd.fill_step) begin
         fill_wr_valid_in = fill_more;
         if (fill_more) begin
            fill_ptr_in = fill_ptr_ff + HEAD_W'(1);
         end
      end
      if (cmd.fill_finish) begin
         head_in     = HEAD_W'(SIZE) - count_ff;
         count_in    = '0;
         refilled_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff          <= '0;
         count_ff         <= '0;
         refilled_ff      <= 1'b0;
         fill_ptr_ff      <= '0;
         fill_wr_valid_ff <= 1'b0;
      end else begin
         head_ff          <= head_in;
         count_ff         <= count_in;
         refilled_ff      <= refilled_in;
         fill_ptr_ff      <= fill_ptr_in;
         fill_wr_valid_ff <= fill_wr_valid_in;
      end
   end

   // Release buffer: written at the fill count, read in order during a refill.
   always_ff @(posedge clock) begin
      if (cmd.buf_write) begin
         buf_mem_ff[count_ff[ADDR_W-1:0]] <= req_index_ff;
      end
      if (cmd.fill_step && fill_more) begin
         fill_data_ff    <= buf_mem_ff[fill_ptr_ff[ADDR_W-1:0]];
         fill_wr_addr_ff <= ADDR_W'(SIZE - 1) - fill_ptr_ff[ADDR_W-1:0];
      end
   end

   // Allocation stack. Until the first refill, the index at the head is not
   // read from the memory but taken as head plus one.
   always_ff @(posedge clock) begin
      if (fill_wr_valid_ff) begin
         stack_mem_ff[fill_wr_addr_ff] <= fill_data_ff;
      end
      if (cmd.stk_read) begin
         stk_rd_ff  <= stack_mem_ff[head_ff[ADDR_W-1:0]];
         fresh_ff   <= head_plus_one[IDX_W-1:0];
         use_mem_ff <= refilled_ff;
      end
   end

   // Request capture, result and response registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_func_ff  <= req_func;
         req_index_ff <= req_index;
      end
      if (cmd.res_load) begin
         res_code_ff <= cmd.res_code;
         if (cmd.res_from_stack) begin
            res_granted_ff <= use_mem_ff ? stk_rd_ff : fresh_ff;
         end else begin
            res_granted_ff <= '0;
         end
      end
      if (cmd.rsp_load) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_status_ff  <= res_code_ff;
      end
   end

   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// File: sv/idx_alloc_ctl.sv
// ----------------------------------------------------------------------------
// idx_alloc_ctl
// Controller: sequences one request at a time and owns the response valid.
// ----------------------------------------------------------------------------
module idx_alloc_ctl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  idx_alloc_pkg::dp_stat_type    stat,
   output idx_alloc_pkg::ctl_cmd_type    cmd,
   output idx_alloc_pkg::state_type      state
);
   import idx_alloc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            priority if (stat.is_release) begin
               state_in = S_DONE;
            end else if (!stat.stack_empty) begin
               state_in = S_FETCH;
            end else if (stat.buf_empty) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (stat.fill_done) begin
               state_in = S_EXEC;
            end
         end
         S_FETCH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      cmd.res_code = RC_OK;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         S_EXEC: begin
            priority if (stat.is_release) begin
               cmd.res_load = 1'b1;
               priority if (stat.idx_zero) begin
                  cmd.res_code = RC_ZERO_INDEX;
               end else if (stat.buf_full) begin
                  cmd.res_code = RC_BUF_FULL;
               end else begin
                  cmd.buf_write = 1'b1;
               end
            end else if (!stat.stack_empty) begin
               cmd.stk_read = 1'b1;
            end else if (stat.buf_empty) begin
               cmd.res_load = 1'b1;
               cmd.res_code = RC_NONE_FREE;
            end else begin
               cmd.fill_start = 1'b1;
            end
         end
         S_FILL: begin
            if (stat.fill_done) begin
               cmd.fill_finish = 1'b1;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         S_FETCH: begin
            cmd.res_load       = 1'b1;
            cmd.res_from_stack = 1'b1;
         end
         S_DONE: begin
            cmd.rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign state     = state_ff;

endmodule

// File: sv/index_allocator_deferred_release.sv
// ----------------------------------------------------------------------------
// index_allocator_deferred_release
// Allocates indexes 1..SIZE from a stack and defers released indexes in a
// buffer that is moved back onto the stack once the stack runs dry.
// ----------------------------------------------------------------------------
// Usage: a request beat on the req_ channel carries req_func (allocate or
// release) and req_index (the index to release, ignored on allocate). Every
// request produces exactly one response beat on the rsp_ channel with the
// granted index (zero unless an allocate succeeded) and a status code.
// The block handles one request at a time; an allocate that gets an index
// passes through a stack read step that a release skips. When an allocate
// finds the stack used up while released indexes wait in the buffer, the
// buffer is copied onto the stack one entry per cycle through the buffer's
// single read port before that one allocate goes on.
// Reset empties the release buffer and points the stack head at its first
// entry; the stack needs no clearing pass and the block is ready right away.
// The response sits in an output register: while the receiver stalls, the
// response holds and the next request is still accepted and worked on; it
// waits at the end of its work until the output register frees up.
// ----------------------------------------------------------------------------
module index_allocator_deferred_release #(
   parameter int SIZE = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [idx_alloc_pkg::IDX_W-1:0]    req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [idx_alloc_pkg::IDX_W-1:0]    rsp_granted_index,
   output logic [idx_alloc_pkg::STATUS_W-1:0] rsp_status
);
   import idx_alloc_pkg::*;

   // Command and status between the controller and the datapath.
   ctl_cmd_type cmd;
   dp_stat_type stat;
   state_type   state;

   // The controller walks each request through capture, execute, an optional
   // refill of the stack, an optional stack read, and the hand-off into the
   // response register.
   idx_alloc_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd),
      .state     (state)
   );

   // The datapath holds both memories, the head pointer, the buffer count
   // and the response payload registers.
   idx_alloc_dp #(
      .SIZE (SIZE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_index         (req_index),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status)
   );

   // A request beat is followed in the next cycle by a stall while it is
   // being worked on.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while the previous one was in progress");

   // Any failure status carries a zero index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != RC_OK) |-> (rsp_granted_index == '0))
      else $error("failed response carries a nonzero index");

   // A completed refill leaves the stack with entries and the buffer empty.
   assert property (@(posedge clock) disable iff (reset)
      (state == S_FILL && stat.fill_done) |=> (!stat.stack_empty && stat.buf_empty))
      else $error("refill left the stack empty or the buffer nonempty");

endmodule

// File: tb/sv/index_allocator_deferred_release_checker.sv
// ----------------------------------------------------------------------------
// index_allocator_deferred_release_checker
// Watches both channels of the index allocator, keeps its own copy of the
// free stack and the deferred release buffer, and compares every response
// beat with the oldest predicted grant.
// ----------------------------------------------------------------------------
module index_allocator_deferred_release_checker #(
   parameter int SIZE = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_func,
   input  logic [idx_alloc_pkg::IDX_W-1:0]    req_index,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [idx_alloc_pkg::IDX_W-1:0]    rsp_granted_index,
   input  logic [idx_alloc_pkg::STATUS_W-1:0] rsp_status,
   output int                                 outstanding,
   output int                                 mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   import idx_alloc_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] granted_index;
      rsp_code_type     status;
   } grant_result_type;

   logic [IDX_W-1:0] free_stack [SIZE];
   int unsigned      stack_top;
   logic [IDX_W-1:0] deferred [SIZE];
   int unsigned      deferred_count;
   grant_result_type grant_queue [$];
   int               error_total = 0;

   // Applies one request to the local allocator state and returns its response.
   function automatic grant_result_type predict_grant(func_type f, logic [IDX_W-1:0] idx);
      grant_result_type r;
      int unsigned      k;
      r.granted_index = '0;
      r.status        = RC_OK;
      if (f == FUNC_ALLOC) begin
         // A dry stack takes back the whole buffer, newest release on top.
         if (stack_top >= SIZE && deferred_count != 0) begin
            for (k = 0; k < deferred_count && stack_top > 0; k++) begin
               stack_top--;
               free_stack[stack_top] = deferred[k];
            end
            deferred_count = 0;
         end
         if (stack_top >= SIZE) begin
            r.status = RC_NONE_FREE;
         end else begin
            r.granted_index       = free_stack[stack_top];
            free_stack[stack_top] = '0;
            stack_top++;
         end
      end else if (idx == '0) begin
         r.status = RC_ZERO_INDEX;
      end else if (deferred_count >= SIZE) begin
         r.status = RC_BUF_FULL;
      end else begin
         deferred[deferred_count] = idx;
         deferred_count++;
      end
      return r;
   endfunction

   task automatic note_mismatch(string msg);
      error_total++;
      if (error_total <= 10) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin : watch
      grant_result_type want;
      if (reset) begin
         for (int i = 0; i < SIZE; i++) begin
            free_stack[i] = IDX_W'(i + 1);
         end
         stack_top      = 0;
         deferred_count = 0;
         grant_queue.delete();
      end else begin
         // Responses are checked before the request of the same edge is queued.
         if (rsp_valid && !rsp_stall) begin
            if (grant_queue.size() == 0) begin
               note_mismatch($sformatf("unexpected response granted_index=%0d status=%0d",
                                       rsp_granted_index, rsp_status));
            end else begin
               want = grant_queue.pop_front();
               if (rsp_granted_index !== want.granted_index || rsp_status !== want.status) begin
                  note_mismatch($sformatf(
                     "granted_index expected %0d got %0d, status expected %s got %0d",
                     want.granted_index, rsp_granted_index, want.status.name(), rsp_status));
               end
            end
         end
         if (req_valid && !req_stall) begin
            grant_queue.push_back(predict_grant(func_type'(req_func), req_index));
         end
      end
      outstanding <= grant_queue.size();
      mismatches  <= error_total;
   end

endmodule

// File: tb/sv/index_allocator_deferred_release_test.sv
// ----------------------------------------------------------------------------
// index_allocator_deferred_release_test
// Drives allocate and release beats into the index allocator, with random
// gaps and receiver stalls, and reports the verdict of the checker module.
// ----------------------------------------------------------------------------
module index_allocator_deferred_release_test;
   timeunit 1ns;
   timeprecision 1ps;

   import idx_alloc_pkg::*;

   localparam int SIZE          = 256;
   localparam int TOTAL_ITEMS   = 1350;
   localparam int IDLE_PCT      = 7;
   // The receiver holds off once, for a long stretch, after this many beats.
   localparam int HOLD_AT_ITEM  = 400;
   localparam int HOLD_CYCLES   = 300;
   // The sender runs without gaps for this range of beats.
   localparam int BUSY_FROM     = 700;
   localparam int BUSY_TO       = 1000;
   // The sender waits for every outstanding response once more at this beat.
   localparam int PAUSE_AT_ITEM = 900;
   // The receiver never stalls in this window of cycles.
   localparam int OPEN_FROM     = 4500;
   localparam int OPEN_TO       = 6500;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum int {
      EP_ALLOC_BURST,
      EP_RELEASE_BURST,
      EP_MIXED,
      EP_NOISE
   } episode_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_func;
   logic [IDX_W-1:0]    req_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [IDX_W-1:0]    rsp_granted_index;
   logic [STATUS_W-1:0] rsp_status;

   int outstanding;
   int mismatches;
   int cycles     = 0;
   int items_sent = 0;

   index_allocator_deferred_release #(
      .SIZE (SIZE)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_index         (req_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status)
   );

   index_allocator_deferred_release_checker #(
      .SIZE (SIZE)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_index         (req_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .outstanding       (outstanding),
      .mismatches        (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a run that has not finished by the limit has hung somewhere.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("index_allocator_deferred_release regression: fail");
      $finish;
   end

   // Receiver. It stalls at random about 7 percent of the time, except for one open window
   // with no stalls at all and one long hold-off. During the hold-off the sender
   // keeps offering beats, so the output register and the request in flight both
   // fill and the block has to stall its request channel.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (cycles >= OPEN_FROM && cycles < OPEN_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Offers one request beat and returns at the edge where it is taken. A gap
   // of idle cycles may come first. Valid stays high from one beat to the next
   // when there is no gap, so it is never lowered and raised in one step.
   task automatic send_request(input func_type f, input logic [IDX_W-1:0] idx);
      int idle_pct;
      idle_pct = (items_sent >= BUSY_FROM && items_sent < BUSY_TO) ? 0 : IDLE_PCT;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_index <= idx;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
   endtask

   // Lowers valid and waits until the checker holds no outstanding grant.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Release indexes are mostly in range; a few are zero or above SIZE.
   function automatic logic [IDX_W-1:0] pick_release_index();
      int r;
      r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 14) return IDX_W'($urandom_range(511, SIZE + 1));
      return IDX_W'($urandom_range(SIZE, 1));
   endfunction

   initial begin
      episode_type kind;
      int          len;
      bit          paused;
      paused = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_func  <= FUNC_ALLOC;
      req_index <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed beats. A zero index is rejected; indexes above SIZE and indexes
      // that are already free are taken as they are, and the allocate index field
      // is ignored even when all its bits are set.
      send_request(FUNC_RELEASE, 9'd0);
      send_request(FUNC_ALLOC,   9'd0);
      send_request(FUNC_ALLOC,   9'd0);
      send_request(FUNC_RELEASE, 9'h1FF);
      send_request(FUNC_RELEASE, 9'd256);
      send_request(FUNC_RELEASE, 9'd1);
      send_request(FUNC_RELEASE, 9'd1);
      send_request(FUNC_RELEASE, 9'd300);
      send_request(FUNC_RELEASE, 9'h155);
      send_request(FUNC_RELEASE, 9'h0AA);
      send_request(FUNC_ALLOC,   9'h1FF);
      send_request(FUNC_ALLOC,   9'h155);
      send_request(FUNC_RELEASE, 9'd0);
      send_request(FUNC_RELEASE, 9'd2);
      send_request(FUNC_ALLOC,   9'h0AA);
      wait_for_drain();

      // Run the stack dry: the allocates past the initial contents pull the
      // buffer back, newest release first, and then report that nothing is free.
      repeat (270) send_request(FUNC_ALLOC, IDX_W'($urandom_range(511)));
      // Overfill the buffer so the last releases are refused, then force the
      // largest possible refill with a single allocate.
      repeat (270) send_request(FUNC_RELEASE, IDX_W'($urandom_range(511, 1)));
      send_request(FUNC_ALLOC, IDX_W'($urandom_range(511)));

      // Random episodes. Bursts of one kind reach the full and empty corners
      // again; mixed and noise episodes shuffle the two functions.
      while (items_sent < TOTAL_ITEMS) begin
         if (!paused && items_sent >= PAUSE_AT_ITEM) begin
            paused = 1'b1;
            wait_for_drain();
         end
         kind = episode_type'($urandom_range(3));
         len  = ($urandom_range(9) == 0) ? 270 : $urandom_range(40, 1);
         if (len > TOTAL_ITEMS - items_sent) begin
            len = TOTAL_ITEMS - items_sent;
         end
         case (kind)
            EP_ALLOC_BURST: begin
               repeat (len) send_request(FUNC_ALLOC, IDX_W'($urandom_range(511)));
            end
            EP_RELEASE_BURST: begin
               repeat (len) send_request(FUNC_RELEASE, pick_release_index());
            end
            EP_MIXED: begin
               repeat (len) begin
                  if ($urandom_range(1) == 0) begin
                     send_request(FUNC_ALLOC, IDX_W'($urandom_range(511)));
                  end else begin
                     send_request(FUNC_RELEASE, pick_release_index());
                  end
               end
            end
            default: begin
               repeat ($urandom_range(10, 1)) begin
                  send_request(func_type'($urandom_range(1)), IDX_W'($urandom_range(511)));
               end
            end
         endcase
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("index_allocator_deferred_release regression: pass");
      end else begin
         $display("index_allocator_deferred_release regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/idx_alloc_pkg.sv
sv/idx_alloc_dp.sv
sv/idx_alloc_ctl.sv
sv/index_allocator_deferred_release.sv
tb/sv/index_allocator_deferred_release_checker.sv
tb/sv/index_allocator_deferred_release_test.sv
